// ===== sv/sca_pkg.sv =====
package sca_pkg;

  localparam int NUM_FRAMES_DEF = 256;
  localparam int CLASS_COUNT = 10;

  // Class index that marks a size above the largest class.
  localparam logic [3:0] CLASS_NONE = 4'd10;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_PAGE   = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_UNMANAGED = 2'd3;

  typedef struct packed {
    logic        is_free;
    logic        size_err;
    logic [3:0]  cls;
    logic        spare_ok;
    logic [7:0]  spare_frame;
    logic [15:0] chunk;
    logic [7:0]  frame;
    logic        frame_ok;
  } cmd_t;

  // Smallest class that holds size; tests run from large to small so the
  // smallest fitting class is the one left standing.
  function automatic logic [3:0] class_of(input logic [15:0] size);
    logic [3:0] c;
    c = CLASS_NONE;
    if (size <= 16'h1000) c = 4'd9;
    if (size <= 16'h0400) c = 4'd8;
    if (size <= 16'h0100) c = 4'd7;
    if (size <= 16'h00c0) c = 4'd6;
    if (size <= 16'h0080) c = 4'd5;
    if (size <= 16'h0060) c = 4'd4;
    if (size <= 16'h0040) c = 4'd3;
    if (size <= 16'h0030) c = 4'd2;
    if (size <= 16'h0020) c = 4'd1;
    if (size <= 16'h0010) c = 4'd0;
    return c;
  endfunction

  // Chunk size of a class in 16-byte units.
  function automatic logic [8:0] class_step(input logic [3:0] cls);
    logic [8:0] s;
    case (cls)
      4'd0:    s = 9'd1;
      4'd1:    s = 9'd2;
      4'd2:    s = 9'd3;
      4'd3:    s = 9'd4;
      4'd4:    s = 9'd6;
      4'd5:    s = 9'd8;
      4'd6:    s = 9'd12;
      4'd7:    s = 9'd16;
      4'd8:    s = 9'd64;
      4'd9:    s = 9'd256;
      default: s = 9'd1;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/sca_front.sv =====
module sca_front #(
  parameter int NUM_FRAMES = sca_pkg::NUM_FRAMES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [15:0]       request_size,
  input  logic [19:0]       chunk_address,
  input  logic              spare_page_valid,
  input  logic [7:0]        spare_page_frame,
  output logic              q_valid,
  input  logic              q_pop,
  output sca_pkg::cmd_t     q_cmd
);

  localparam logic [16:0] FRAME_LIMIT = 17'(NUM_FRAMES);

  sca_pkg::cmd_t cmd_in;
  sca_pkg::cmd_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  logic [3:0] cls;

  assign cls = sca_pkg::class_of(request_size);

  always_comb begin
    cmd_in.is_free     = opcode;
    cmd_in.size_err    = (cls == sca_pkg::CLASS_NONE);
    cmd_in.cls         = cls;
    cmd_in.spare_ok    = spare_page_valid && ({9'd0, spare_page_frame} < FRAME_LIMIT);
    cmd_in.spare_frame = spare_page_frame;
    cmd_in.chunk       = chunk_address[19:4];
    cmd_in.frame       = chunk_address[19:12];
    cmd_in.frame_ok    = ({9'd0, chunk_address[19:12]} < FRAME_LIMIT);
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = mem[rptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/sca_back.sv =====
module sca_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  sca_pkg::cmd_t     q_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [19:0]       granted_address,
  output logic              page_consumed
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_CARVE, S_POP, S_POPRD} state_t;

  state_t        state;
  sca_pkg::cmd_t cmd;
  logic [9:0]    nonempty;
  logic [15:0]   head [10];
  logic [15:0]   tail [10];
  logic [255:0]  mark_valid;
  logic [15:0]   cur;
  logic [8:0]    off;
  logic [8:0]    step;

  logic [15:0]   link_mem [65536];
  logic [15:0]   link_rdata;
  logic [3:0]    mark_mem [256];
  logic [3:0]    mark_rdata;

  logic          link_we;
  logic [15:0]   link_waddr;
  logic [15:0]   link_wdata;
  logic [15:0]   link_raddr;
  logic          mark_we;
  logic [8:0]    nxt_off;
  logic          more;
  logic          free_ok;
  logic          carve_start;

  assign q_pop   = (state == S_IDLE) && q_valid && !out_valid;
  assign nxt_off = off + step;
  // Another chunk fits when the next one still ends inside the page.
  assign more    = ({1'b0, nxt_off} + {1'b0, step}) <= 10'd256;
  assign free_ok = cmd.frame_ok && mark_valid[cmd.frame] && (mark_rdata < 4'd10);
  assign carve_start = (state == S_EXEC) && !cmd.is_free && !cmd.size_err
                       && !nonempty[cmd.cls] && cmd.spare_ok;
  assign mark_we = carve_start;
  assign link_raddr = head[cmd.cls];

  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur;
    link_wdata = cur + {7'd0, step};
    if (state == S_CARVE) begin
      link_we = more;
    end else if (state == S_EXEC && cmd.is_free) begin
      link_we    = free_ok && nonempty[mark_rdata];
      link_waddr = cmd.chunk;
      link_wdata = head[mark_rdata];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rdata <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[cmd.spare_frame] <= cmd.cls;
    mark_rdata <= mark_mem[q_cmd.frame];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      nonempty   <= '0;
      mark_valid <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cmd   <= q_cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          granted_address <= '0;
          page_consumed   <= 1'b0;
          if (cmd.is_free) begin
            status    <= free_ok ? sca_pkg::ST_OK : sca_pkg::ST_UNMANAGED;
            out_valid <= 1'b1;
            if (free_ok) begin
              if (!nonempty[mark_rdata]) begin
                tail[mark_rdata]     <= cmd.chunk;
                nonempty[mark_rdata] <= 1'b1;
              end
              head[mark_rdata] <= cmd.chunk;
            end
            state <= S_IDLE;
          end else if (cmd.size_err) begin
            status    <= sca_pkg::ST_TOO_LARGE;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (nonempty[cmd.cls]) begin
            state <= S_POP;
          end else if (cmd.spare_ok) begin
            mark_valid[cmd.spare_frame] <= 1'b1;
            head[cmd.cls] <= {cmd.spare_frame, 8'h00};
            cur           <= {cmd.spare_frame, 8'h00};
            off           <= 9'd0;
            step          <= sca_pkg::class_step(cmd.cls);
            page_consumed <= 1'b1;
            state         <= S_CARVE;
          end else begin
            status    <= sca_pkg::ST_NO_PAGE;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_CARVE: begin
          if (more) begin
            cur <= cur + {7'd0, step};
            off <= nxt_off;
          end else begin
            tail[cmd.cls]     <= cur;
            nonempty[cmd.cls] <= 1'b1;
            state             <= S_POP;
          end
        end
        S_POP: begin
          granted_address <= {head[cmd.cls], 4'h0};
          status          <= sca_pkg::ST_OK;
          out_valid       <= 1'b1;
          if (head[cmd.cls] == tail[cmd.cls]) begin
            nonempty[cmd.cls] <= 1'b0;
            state             <= S_IDLE;
          end else begin
            state <= S_POPRD;
          end
        end
        S_POPRD: begin
          head[cmd.cls] <= link_rdata;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/size_class_chunk_allocator.sv =====
// Chunk allocator with ten size classes over 4 KiB frames. Requests enter a
// two-entry queue, so up to two requests are taken while a result waits.
// A free reads the frame-mark memory and an allocate from a non-empty list the
// link memory, both through registered reads. An allocate that finds its list
// empty carves the spare page first, writing one link per cycle for every chunk
// of the class but the last. Reset needs no clearing pass: frame marks carry
// valid flops that reset clears at once.
module size_class_chunk_allocator #(
  parameter int NUM_FRAMES = sca_pkg::NUM_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [15:0] request_size,
  input  logic [19:0] chunk_address,
  input  logic        spare_page_valid,
  input  logic [7:0]  spare_page_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [19:0] granted_address,
  output logic        page_consumed
);

  sca_pkg::cmd_t q_cmd;
  logic          q_valid;
  logic          q_pop;

  sca_front #(.NUM_FRAMES(NUM_FRAMES)) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .request_size     (request_size),
    .chunk_address    (chunk_address),
    .spare_page_valid (spare_page_valid),
    .spare_page_frame (spare_page_frame),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_cmd            (q_cmd)
  );

  sca_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_cmd           (q_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_address (granted_address),
    .page_consumed   (page_consumed)
  );

  // A carved page always yields a grant.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && page_consumed |-> status == sca_pkg::ST_OK)
    else $error("page consumed without a grant");

  // Failed requests grant nothing.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != sca_pkg::ST_OK |-> granted_address == 20'd0)
    else $error("nonzero address on a failed request");

  // Granted chunks are 16-byte aligned.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> granted_address[3:0] == 4'd0)
    else $error("misaligned grant");

endmodule

// ===== test/chunk_alloc_checker.sv =====
`timescale 1ns / 1ps

module chunk_alloc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        opcode,
  input  logic [15:0] request_size,
  input  logic [19:0] chunk_address,
  input  logic        spare_page_valid,
  input  logic [7:0]  spare_page_frame,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [19:0] granted_address,
  input  logic        page_consumed,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] addr;
    logic        consumed;
  } grant_t;

  // Chunk size of each class in 16-byte units.
  localparam int unsigned CHUNK_UNITS [sca_pkg::CLASS_COUNT] =
    '{1, 2, 3, 4, 6, 8, 12, 16, 64, 256};

  grant_t      grant_q[$];
  logic [4:0]  frame_mark [256];
  logic        list_full [sca_pkg::CLASS_COUNT];
  logic [15:0] list_first [sca_pkg::CLASS_COUNT];
  logic [15:0] list_last [sca_pkg::CLASS_COUNT];
  logic [15:0] chunk_next [65536];

  assign pending = grant_q.size();

  function automatic void split_page(input int cls, input logic [7:0] frame);
    logic [15:0] base;
    logic [15:0] prev;
    int          k;
    base = {frame, 8'h00};
    prev = base;
    frame_mark[frame] = {1'b1, 4'(cls)};
    list_first[cls] = base;
    for (k = CHUNK_UNITS[cls]; k + CHUNK_UNITS[cls] <= 256; k += CHUNK_UNITS[cls]) begin
      chunk_next[prev] = base + 16'(k);
      prev = base + 16'(k);
    end
    list_last[cls] = prev;
    list_full[cls] = 1'b1;
  endfunction

  function automatic grant_t serve_request(input logic is_free, input logic [15:0] size,
                                           input logic [19:0] addr, input logic spare_ok,
                                           input logic [7:0] spare);
    grant_t      r;
    int          cls;
    logic [15:0] chunk;
    logic [4:0]  mark;
    r = '0;
    r.status = sca_pkg::ST_OK;
    if (!is_free) begin
      cls = sca_pkg::CLASS_COUNT;
      for (int c = sca_pkg::CLASS_COUNT - 1; c >= 0; c--)
        if (size <= 16'(CHUNK_UNITS[c] * 16)) cls = c;
      if (cls == sca_pkg::CLASS_COUNT) begin
        r.status = sca_pkg::ST_TOO_LARGE;
      end else begin
        if (!list_full[cls]) begin
          if (spare_ok) begin
            split_page(cls, spare);
            r.consumed = 1'b1;
          end else begin
            r.status = sca_pkg::ST_NO_PAGE;
          end
        end
        if (r.status == sca_pkg::ST_OK) begin
          chunk = list_first[cls];
          r.addr = {chunk, 4'h0};
          if (chunk == list_last[cls]) list_full[cls] = 1'b0;
          else list_first[cls] = chunk_next[chunk];
        end
      end
    end else begin
      mark = frame_mark[addr[19:12]];
      if (!mark[4] || mark[3:0] >= sca_pkg::CLASS_COUNT) begin
        r.status = sca_pkg::ST_UNMANAGED;
      end else begin
        cls = mark[3:0];
        chunk = addr[19:4];
        if (list_full[cls]) chunk_next[chunk] = list_first[cls];
        else begin
          list_last[cls] = chunk;
          list_full[cls] = 1'b1;
        end
        list_first[cls] = chunk;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    int     errs;
    errs = 0;
    if (rst) begin
      grant_q.delete();
      fail_count <= 0;
      for (int f = 0; f < 256; f++) frame_mark[f] = '0;
      for (int c = 0; c < sca_pkg::CLASS_COUNT; c++) list_full[c] = 1'b0;
    end else begin
      if (in_valid && in_ready)
        grant_q.push_back(serve_request(opcode, request_size, chunk_address,
                                        spare_page_valid, spare_page_frame));
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result: status %0d address %h", status, granted_address);
          errs++;
        end else begin
          want = grant_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errs++;
          end
          if (granted_address !== want.addr) begin
            $error("granted_address: expected %h, got %h", want.addr, granted_address);
            errs++;
          end
          if (page_consumed !== want.consumed) begin
            $error("page_consumed: expected %0d, got %0d", want.consumed, page_consumed);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ===== test/tb_size_class_chunk_allocator.sv =====
`timescale 1ns / 1ps

module tb_size_class_chunk_allocator;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam int   RANDOM_ITEMS = 500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = OP_ALLOC;
  logic [15:0] request_size = '0;
  logic [19:0] chunk_address = '0;
  logic        spare_page_valid = 1'b0;
  logic [7:0]  spare_page_frame = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [19:0] granted_address;
  logic        page_consumed;
  int          fail_count;
  int          pending;
  bit          quiet = 1'b0;
  int          alloc_count = 0;
  int          free_count = 0;
  logic [7:0]  frame_pool [16];

  always #4 clk = ~clk;

  size_class_chunk_allocator DUT (.*);

  chunk_alloc_checker checker_i (.*);

  // Result side stalls in random bursts until the quiet tail of the run.
  initial begin
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  task automatic send(input logic op, input logic [15:0] size, input logic [19:0] addr,
                      input logic spare_ok, input logic [7:0] spare);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode = op;
    request_size = size;
    chunk_address = addr;
    spare_page_valid = spare_ok;
    spare_page_frame = spare;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (op == OP_ALLOC) alloc_count++;
    else free_count++;
  endtask

  function automatic logic [15:0] pick_size();
    logic [15:0] edges [12] = '{0, 16, 17, 32, 48, 64, 96, 128, 192, 256, 1024, 4096};
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 16'($urandom_range(4097, 65535));
    if (roll < 45) return edges[$urandom_range(0, 11)] + 16'($urandom_range(0, 1));
    if (roll < 80) return 16'($urandom_range(17, 1024));
    return 16'($urandom_range(0, 4096));
  endfunction

  initial begin
    int roll;
    for (int i = 0; i < 16; i++) frame_pool[i] = 8'($urandom_range(0, 255));
    frame_pool[0] = 8'h00;
    frame_pool[1] = 8'hff;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: empty lists without a page, the size edges, unmanaged and
    // misaligned frees, a double free and a page offered a second time.
    send(OP_ALLOC, 16'd16, 20'h0, 1'b0, 8'h00);
    send(OP_FREE, 16'h0, 20'h00000, 1'b0, 8'h00);
    send(OP_ALLOC, 16'd0, 20'h0, 1'b1, 8'h00);
    send(OP_ALLOC, 16'd16, 20'h0, 1'b1, 8'h01);
    send(OP_ALLOC, 16'd4097, 20'h0, 1'b1, 8'h02);
    send(OP_ALLOC, 16'hffff, 20'hfffff, 1'b1, 8'hff);
    send(OP_ALLOC, 16'd4096, 20'h0, 1'b1, 8'hff);
    send(OP_ALLOC, 16'd4096, 20'h0, 1'b1, 8'h10);
    send(OP_ALLOC, 16'd1024, 20'h0, 1'b0, 8'h00);
    send(OP_FREE, 16'h0, 20'hfffff, 1'b0, 8'h00);
    send(OP_FREE, 16'h0, 20'hff000, 1'b0, 8'h00);
    send(OP_ALLOC, 16'd4000, 20'h0, 1'b0, 8'h00);
    send(OP_FREE, 16'h0, 20'h0000f, 1'b0, 8'h00);
    send(OP_FREE, 16'h0, 20'h00010, 1'b0, 8'h00);
    send(OP_FREE, 16'h0, 20'h00010, 1'b0, 8'h00);
    send(OP_ALLOC, 16'd1, 20'h0, 1'b0, 8'h00);
    send(OP_ALLOC, 16'd1, 20'h0, 1'b0, 8'h00);
    send(OP_FREE, 16'h0, 20'h7a123, 1'b1, 8'h7a);
    send(OP_ALLOC, 16'd17, 20'h0, 1'b1, 8'h00);
    send(OP_ALLOC, 16'd193, 20'h0, 1'b1, 8'h01);
    send(OP_ALLOC, 16'd4096, 20'h0, 1'b1, 8'h00);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - 80) quiet = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 60)
        send(OP_ALLOC, pick_size(), 20'($urandom), $urandom_range(0, 99) < 85,
             $urandom_range(0, 4) == 0 ? 8'($urandom) : frame_pool[$urandom_range(0, 15)]);
      else if (roll < 92)
        send(OP_FREE, 16'($urandom), {frame_pool[$urandom_range(0, 15)], 12'($urandom)},
             1'($urandom), 8'($urandom));
      else
        send(OP_FREE, 16'($urandom), 20'($urandom), 1'($urandom), 8'($urandom));
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Ran %0d allocate and %0d free requests over random size classes and frames,",
             alloc_count, free_count);
    $display("with page carving, unmanaged frees and stalls on both sides.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS size_class_chunk_allocator");
    end else begin
      $display("FAIL size_class_chunk_allocator");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL size_class_chunk_allocator");
    $finish;
  end
endmodule
